// ----- sv/npg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npg_pkg: shared types and constants of the permutation generator
// Field widths, command and status bundles, controller states.
// ----------------------------------------------------------------------------
package npg_pkg;

   localparam int MAX_ELEMENTS_DEF = 16;
   localparam int VALUE_W          = 16;
   localparam int COUNT_W          = 5;
   localparam int LOAD_IDX_W       = 4;
   localparam int POS_W            = 4;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIV_FIRST,
      ST_PIV_LOOP,
      ST_EMIT_LD,
      ST_EMIT_WAIT,
      ST_TGT_LOOP,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_REV_CHK,
      ST_REV_RA,
      ST_REV_RB,
      ST_REV_WB
   } state_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_LAST,
      IDX_ZERO,
      IDX_DEC,
      IDX_INC,
      IDX_LO,
      IDX_HI
   } idx_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_LOAD,
      WR_PIVOT,
      WR_TARGET,
      WR_LO,
      WR_HI
   } wr_sel_type;

   typedef enum logic [1:0] {
      REV_HOLD,
      REV_FULL,
      REV_SUFFIX,
      REV_STEP
   } rev_sel_type;

   typedef struct packed {
      idx_sel_type idx_sel;
      wr_sel_type  wr_sel;
      rev_sel_type rev_sel;
      logic        load_right;
      logic        load_pivot;
      logic        load_low;
      logic        load_rsp;
      logic        wrap_clr;
      logic        wrap_set;
   } cmd_type;

   typedef struct packed {
      logic idx_zero;
      logic idx_last;
      logic less_right;
      logic pv_less;
      logic rev_more;
      logic wrapped;
   } status_type;

endpackage

// ----- sv/npg_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npg_req_if: request channel
// Load or step beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface npg_req_if import npg_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [LOAD_IDX_W-1:0]        load_index;
   logic signed [VALUE_W-1:0]    load_value;

   modport source (output valid, output op, output load_index, output load_value,
                   input ready);
   modport sink   (input valid, input op, input load_index, input load_value,
                   output ready);
endinterface

// ----- sv/npg_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npg_rsp_if: response channel
// One beat per emitted arrangement element, valid/ready handshake.
// ----------------------------------------------------------------------------
interface npg_rsp_if import npg_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_W-1:0]    element_value;
   logic [POS_W-1:0]             element_position;
   logic                         last_element;
   logic                         wrapped;

   modport source (output valid, output element_value, output element_position,
                   output last_element, output wrapped, input ready);
   modport sink   (input valid, input element_value, input element_position,
                   input last_element, input wrapped, output ready);
endinterface

// ----- sv/next_permutation_generator_unit.sv -----
// Load beat: accepted from idle, no response beats; the next beat may follow at once.
// Step beat: emits the arrangement, then advances it in place; rsp stalls hold the emit, and a
//   step holds req ready low until its advance is done, so one step runs at a time.
// Reset: synchronous, active high; count returns to 16, arrangement is unknown until loaded.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_permutation_generator_unit: lexicographic permutation stepper
// Holds a signed arrangement in RAM; a step beat emits it and then advances
// it in place to the next lexicographic permutation.
// ----------------------------------------------------------------------------
module next_permutation_generator_unit import npg_pkg::*; #(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   npg_req_if.sink            req_bus,
   npg_rsp_if.source          rsp_bus,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_element_count
);

   localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

   // Sequence of one step beat:
   //   1. scan down from the last entry for the rightmost ascent (pivot);
   //      no ascent means the whole arrangement reverses and wrapped is set,
   //      so the flag is known before the first response beat leaves
   //   2. emit entries 0..n-1, one read and one response beat each
   //   3. scan down again for the rightmost entry above the pivot
   //   4. swap pivot and that entry, two writes
   //   5. reverse the suffix (or everything on wrap), one pair of entries at a time

   cmd_type              cmd;
   status_type           status;
   logic                 ram_wr_en;
   logic [IW-1:0]        ram_wr_addr;
   logic [VALUE_W-1:0]   ram_wr_data;
   logic [IW-1:0]        ram_rd_addr;
   logic [VALUE_W-1:0]   ram_rd_data;

   // the user must change the count only between steps; the block does not enforce it and always takes the write
   assign csr_ready = 1'b1;

   npg_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   npg_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg_we       (csr_valid && csr_ready),
      .cfg_data     (csr_element_count),
      .req_index    (req_bus.load_index),
      .req_value    (req_bus.load_value),
      .cmd          (cmd),
      .status       (status),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .out_value    (rsp_bus.element_value),
      .out_position (rsp_bus.element_position),
      .out_last     (rsp_bus.last_element),
      .out_wrapped  (rsp_bus.wrapped)
   );

   // arrangement storage
   npg_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ----- sv/npg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npg_ram: generic single-write, single-read RAM
// Registered read data, no reset on the storage.
// ----------------------------------------------------------------------------
module npg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/npg_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npg_controller: sequencer of the permutation generator
// Walks pivot scan, emit, target scan, swap and suffix reversal.
// ----------------------------------------------------------------------------
module npg_controller import npg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_op,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      is_step;

   assign is_step = (op_type'(req_op) == OP_STEP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && is_step) begin
               state_in = ST_PIV_FIRST;
            end
         end
         ST_PIV_FIRST: begin
            state_in = status.idx_zero ? ST_EMIT_LD : ST_PIV_LOOP;
         end
         ST_PIV_LOOP: begin
            if (status.less_right || status.idx_zero) begin
               state_in = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD: begin
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rsp_ready) begin
               if (!status.idx_last) begin
                  state_in = ST_EMIT_LD;
               end else if (status.wrapped) begin
                  state_in = ST_REV_CHK;
               end else begin
                  state_in = ST_TGT_LOOP;
               end
            end
         end
         ST_TGT_LOOP: begin
            if (status.pv_less) begin
               state_in = ST_SWAP_A;
            end
         end
         ST_SWAP_A: begin
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            state_in = ST_REV_CHK;
         end
         ST_REV_CHK: begin
            state_in = status.rev_more ? ST_REV_RA : ST_IDLE;
         end
         ST_REV_RA: begin
            state_in = ST_REV_RB;
         end
         ST_REV_RB: begin
            state_in = ST_REV_WB;
         end
         ST_REV_WB: begin
            state_in = ST_REV_CHK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      cmd            = '0;
      cmd.idx_sel    = IDX_HOLD;
      cmd.wr_sel     = WR_NONE;
      cmd.rev_sel    = REV_HOLD;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (is_step) begin
                  cmd.idx_sel  = IDX_LAST;
                  cmd.wrap_clr = 1'b1;
               end else begin
                  cmd.wr_sel = WR_LOAD;
               end
            end
         end
         ST_PIV_FIRST: begin
            cmd.load_right = 1'b1;
            if (status.idx_zero) begin
               cmd.wrap_set = 1'b1;
               cmd.idx_sel  = IDX_ZERO;
            end else begin
               cmd.idx_sel = IDX_DEC;
            end
         end
         ST_PIV_LOOP: begin
            if (status.less_right) begin
               cmd.load_pivot = 1'b1;
               cmd.idx_sel    = IDX_ZERO;
            end else begin
               cmd.load_right = 1'b1;
               if (status.idx_zero) begin
                  cmd.wrap_set = 1'b1;
                  cmd.idx_sel  = IDX_ZERO;
               end else begin
                  cmd.idx_sel = IDX_DEC;
               end
            end
         end
         ST_EMIT_LD: begin
            cmd.load_rsp = 1'b1;
         end
         ST_EMIT_WAIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (!status.idx_last) begin
                  cmd.idx_sel = IDX_INC;
               end else if (status.wrapped) begin
                  cmd.rev_sel = REV_FULL;
               end else begin
                  cmd.idx_sel = IDX_LAST;
               end
            end
         end
         ST_TGT_LOOP: begin
            if (!status.pv_less) begin
               cmd.idx_sel = IDX_DEC;
            end
         end
         ST_SWAP_A: begin
            cmd.wr_sel = WR_PIVOT;
         end
         ST_SWAP_B: begin
            cmd.wr_sel  = WR_TARGET;
            cmd.rev_sel = REV_SUFFIX;
         end
         ST_REV_CHK: begin
            if (status.rev_more) begin
               cmd.idx_sel = IDX_LO;
            end
         end
         ST_REV_RA: begin
            cmd.load_low = 1'b1;
            cmd.idx_sel  = IDX_HI;
         end
         ST_REV_RB: begin
            cmd.wr_sel = WR_LO;
         end
         ST_REV_WB: begin
            cmd.wr_sel  = WR_HI;
            cmd.rev_sel = REV_STEP;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- sv/npg_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npg_datapath: registers, compares and RAM access of the generator
// Read address is the next index, so read data always matches idx_ff.
// ----------------------------------------------------------------------------
module npg_datapath import npg_pkg::*; #(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
   localparam int IW          = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cfg_we,
   input  logic [COUNT_W-1:0]        cfg_data,
   input  logic [LOAD_IDX_W-1:0]     req_index,
   input  logic signed [VALUE_W-1:0] req_value,
   input  cmd_type                   cmd,
   output status_type                status,
   output logic                      ram_wr_en,
   output logic [IW-1:0]             ram_wr_addr,
   output logic [VALUE_W-1:0]        ram_wr_data,
   output logic [IW-1:0]             ram_rd_addr,
   input  logic [VALUE_W-1:0]        ram_rd_data,
   output logic signed [VALUE_W-1:0] out_value,
   output logic [POS_W-1:0]          out_position,
   output logic                      out_last,
   output logic                      out_wrapped
);

   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic [IW-1:0]             pivot_ff, pivot_in;
   logic [IW-1:0]             lo_ff, lo_in;
   logic [IW-1:0]             hi_ff, hi_in;
   logic signed [VALUE_W-1:0] right_ff, right_in;
   logic signed [VALUE_W-1:0] pv_ff, pv_in;
   logic signed [VALUE_W-1:0] vlo_ff, vlo_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic                      last_ff, last_in;
   logic                      wrap_ff, wrap_in;

   logic [IW-1:0]             last_idx;
   logic signed [VALUE_W-1:0] rdata;
   logic                      in_range;

   assign rdata    = $signed(ram_rd_data);
   assign in_range = (32'(req_index) < 32'(MAX_ELEMENTS));

   // clamp the count register to 1..MAX_ELEMENTS, as a last index
   always_comb begin
      if (count_ff == '0) begin
         last_idx = '0;
      end else if (32'(count_ff) > 32'(MAX_ELEMENTS)) begin
         last_idx = IW'(MAX_ELEMENTS - 1);
      end else begin
         last_idx = IW'(count_ff - COUNT_W'(1));
      end
   end

   always_comb begin
      case (cmd.idx_sel)
         IDX_HOLD: idx_in = idx_ff;
         IDX_LAST: idx_in = last_idx;
         IDX_ZERO: idx_in = '0;
         IDX_DEC:  idx_in = idx_ff - IW'(1);
         IDX_INC:  idx_in = idx_ff + IW'(1);
         IDX_LO:   idx_in = lo_ff;
         IDX_HI:   idx_in = hi_ff;
         default:  idx_in = idx_ff;
      endcase
   end

   assign ram_rd_addr = idx_in;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = ram_rd_data;
      case (cmd.wr_sel)
         WR_NONE: begin
            ram_wr_en = 1'b0;
         end
         WR_LOAD: begin
            ram_wr_en   = in_range;
            ram_wr_addr = IW'(req_index);
            ram_wr_data = req_value;
         end
         WR_PIVOT: begin
            // read data still holds the swap target entry
            ram_wr_en   = 1'b1;
            ram_wr_addr = pivot_ff;
            ram_wr_data = ram_rd_data;
         end
         WR_TARGET: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = pv_ff;
         end
         WR_LO: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = lo_ff;
            ram_wr_data = ram_rd_data;
         end
         WR_HI: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = hi_ff;
            ram_wr_data = vlo_ff;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in = cfg_we ? cfg_data : count_ff;
      right_in = cmd.load_right ? rdata : right_ff;
      pivot_in = cmd.load_pivot ? idx_ff : pivot_ff;
      pv_in    = cmd.load_pivot ? rdata : pv_ff;
      vlo_in   = cmd.load_low ? rdata : vlo_ff;
      value_in = cmd.load_rsp ? rdata : value_ff;
      pos_in   = cmd.load_rsp ? POS_W'(idx_ff) : pos_ff;
      last_in  = cmd.load_rsp ? (idx_ff == last_idx) : last_ff;
      wrap_in  = wrap_ff;
      if (cmd.wrap_clr) begin
         wrap_in = 1'b0;
      end else if (cmd.wrap_set) begin
         wrap_in = 1'b1;
      end
      lo_in = lo_ff;
      hi_in = hi_ff;
      case (cmd.rev_sel)
         REV_HOLD: begin
            lo_in = lo_ff;
         end
         REV_FULL: begin
            lo_in = '0;
            hi_in = last_idx;
         end
         REV_SUFFIX: begin
            lo_in = pivot_ff + IW'(1);
            hi_in = last_idx;
         end
         REV_STEP: begin
            lo_in = lo_ff + IW'(1);
            hi_in = hi_ff - IW'(1);
         end
         default: begin
            lo_in = lo_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         idx_ff   <= '0;
         wrap_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
         wrap_ff  <= wrap_in;
      end
   end

   always_ff @(posedge clock) begin
      right_ff <= right_in;
      pivot_ff <= pivot_in;
      pv_ff    <= pv_in;
      vlo_ff   <= vlo_in;
      value_ff <= value_in;
      pos_ff   <= pos_in;
      last_ff  <= last_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
   end

   assign status.idx_zero   = (idx_ff == '0);
   assign status.idx_last   = (idx_ff == last_idx);
   assign status.less_right = (rdata < right_ff);
   assign status.pv_less    = (pv_ff < rdata);
   assign status.rev_more   = (lo_ff < hi_ff);
   assign status.wrapped    = wrap_ff;

   assign out_value    = value_ff;
   assign out_position = pos_ff;
   assign out_last     = last_ff;
   assign out_wrapped  = wrap_ff;

endmodule
